### sv/name_keyed_plaintext_feedback_decipher_core_defines.svh
// Assertion macros used by the decipher core checker.
`ifndef NAME_KEYED_PLAINTEXT_FEEDBACK_DECIPHER_CORE_DEFINES_SVH
`define NAME_KEYED_PLAINTEXT_FEEDBACK_DECIPHER_CORE_DEFINES_SVH

// Plain property check, disabled while reset is asserted.
`define NKPFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nkpfd assertion failed");

// A signal holds its value in the cycle after a condition was seen.
`define NKPFD_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) \
        else $error("nkpfd signal changed while held");

`endif

### sv/nkpfd_pkg.sv
// Types and constants of the name-keyed plaintext-feedback decipher.
`default_nettype none

package nkpfd_pkg;

    typedef enum logic [1:0] {
        MODE_NAME   = 2'd0,
        MODE_CIPHER = 2'd1,
        MODE_REWIND = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] byte_in;
    } item_t;

    // key_value sits above data_out, matching the output tdata layout
    typedef struct packed {
        logic signed [31:0] key_value;
        logic [7:0]         data_out;
    } result_t;

    localparam logic [31:0] MUL_STEP      = 32'd498729871;
    localparam logic [31:0] ADD_STEP      = 32'd85731;
    localparam logic [31:0] HASH_MUL      = 32'd31;
    localparam logic [7:0]  SEP_SLASH     = 8'h2F;
    localparam logic [7:0]  SEP_BACKSLASH = 8'h5C;

endpackage

`default_nettype wire

### sv/name_keyed_plaintext_feedback_decipher_core.sv
// An accepted item passes through the input register and then the result register
// before it is offered on the output.
// Throughput: one item per cycle while the output is not stalled; the state update is two
// 32x32 multiplies and an add between the input register and the state and result registers.
// Reset clears the name hash and keystream state to zero and empties both
// register stages.
`default_nettype none

module name_keyed_plaintext_feedback_decipher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // [7:0] data_out, [39:8] key_value
);
    import nkpfd_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;

    assign in_item.mode    = mode_t'(s_axis_tuser);
    assign in_item.byte_in = s_axis_tdata;

    // the held item moves on when the result register is free or being drained
    assign advance = !out_valid_reg || m_axis_tready;

    nkpfd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    nkpfd_keystream u_keystream (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .load   (advance && item_valid),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

`default_nettype wire

### sv/nkpfd_in_reg.sv
// Input register stage of the decipher core.
`default_nettype none

module nkpfd_in_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire nkpfd_pkg::item_t in_item,
    input  wire logic            advance,
    output logic                 item_valid,
    output nkpfd_pkg::item_t     item
);
    import nkpfd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // take a new transaction when none is held or the held one moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### sv/nkpfd_keystream.sv
// Name hash and keystream state with their update logic.
`default_nettype none

module nkpfd_keystream (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire nkpfd_pkg::item_t item,
    input  wire logic             load,
    output nkpfd_pkg::result_t    result
);
    import nkpfd_pkg::*;

    logic [31:0] name_hash_reg;
    logic [31:0] name_hash_next;
    logic [31:0] ks_reg;
    logic [31:0] ks_next;
    logic [7:0]  plain;
    logic [31:0] plain_ext;
    logic [31:0] ks_scaled;
    logic [31:0] plain_scaled;
    logic        is_sep;

    assign is_sep       = (item.byte_in == SEP_SLASH) || (item.byte_in == SEP_BACKSLASH);
    assign plain        = item.byte_in ^ ks_reg[15:8];
    assign plain_ext    = {{24{plain[7]}}, plain};
    assign ks_scaled    = ks_reg * MUL_STEP;
    assign plain_scaled = plain_ext * ADD_STEP;

    always_comb
    begin
        name_hash_next = name_hash_reg;
        ks_next        = ks_reg;
        result.data_out = 8'd0;
        unique case (item.mode)
            MODE_NAME:
            begin
                if (is_sep)
                begin
                    name_hash_next = 32'd0;
                end
                else
                begin
                    name_hash_next = name_hash_reg * HASH_MUL + {24'd0, item.byte_in};
                end
                ks_next = name_hash_next;
            end
            MODE_CIPHER:
            begin
                result.data_out = plain;
                ks_next         = ks_scaled + plain_scaled;
            end
            MODE_REWIND:
            begin
                ks_next = name_hash_reg;
            end
            MODE_CLEAR:
            begin
                name_hash_next = 32'd0;
            end
            default:
            begin
                ks_next = ks_reg;
            end
        endcase
        result.key_value = signed'(ks_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_hash_reg <= 32'd0;
            ks_reg        <= 32'd0;
        end
        else if (load)
        begin
            name_hash_reg <= name_hash_next;
            ks_reg        <= ks_next;
        end
    end

endmodule

`default_nettype wire

### sv/nkpfd_checker.sv
// Port-level checker for the decipher core, bound to the top level.
`default_nettype none
`include "name_keyed_plaintext_feedback_decipher_core_defines.svh"

module nkpfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    // a stalled result stays offered and unchanged
    `NKPFD_ASSERT(a_out_valid_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `NKPFD_ASSERT_HOLD(a_out_data_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tdata)

    // input backpressure only comes from a full, stalled output
    `NKPFD_ASSERT(a_stall_cause, clk, rst_n, !s_axis_tready |-> m_axis_tvalid)

    // an empty output fills only from an input transaction that moved from the input register into the result register
    `NKPFD_ASSERT(a_fill_latency, clk, rst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind name_keyed_plaintext_feedback_decipher_core nkpfd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the name-keyed plaintext-feedback decipher core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nkpfd_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 200;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  byte_val;
        logic        typed;
        logic [7:0]  exp_plain;
        logic [31:0] exp_key;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_in
    logic [1:0]  s_axis_tuser = 2'b00;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [7:0] data_out, [39:8] key_value

    // predictor state
    logic [31:0] name_key = '0;
    logic [31:0] stream_key = '0;

    result_t pending_plain [$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      items_sent = 0;
    int      results_checked = 0;
    int      mode_seen [4] = '{0, 0, 0, 0};
    int      src_idle_pct = 30;
    int      sink_stall_pct = 54;

    stim_row_t directed_rows [20] = '{
        '{MODE_CIPHER, 8'h00, 1'b1, 8'h00, 32'h0000_0000},
        '{MODE_CIPHER, 8'hFF, 1'b1, 8'hFF, 32'hFFFE_B11D},
        '{MODE_REWIND, 8'h00, 1'b1, 8'h00, 32'h0000_0000},
        '{MODE_NAME,   8'hFF, 1'b1, 8'h00, 32'h0000_00FF},
        '{MODE_NAME,   8'h2F, 1'b1, 8'h00, 32'h0000_0000},
        '{MODE_NAME,   8'h80, 1'b1, 8'h00, 32'h0000_0080},
        '{MODE_NAME,   8'h5C, 1'b1, 8'h00, 32'h0000_0000},
        '{MODE_NAME,   8'h00, 1'b1, 8'h00, 32'h0000_0000},
        '{MODE_NAME,   8'h41, 1'b1, 8'h00, 32'h0000_0041},
        '{MODE_NAME,   8'h42, 1'b0, 8'h00, 32'h0},
        '{MODE_CIPHER, 8'h00, 1'b0, 8'h00, 32'h0},
        '{MODE_CIPHER, 8'hFF, 1'b0, 8'h00, 32'h0},
        '{MODE_CIPHER, 8'h80, 1'b0, 8'h00, 32'h0},
        '{MODE_CIPHER, 8'h7F, 1'b0, 8'h00, 32'h0},
        '{MODE_REWIND, 8'hFF, 1'b0, 8'h00, 32'h0},
        '{MODE_CLEAR,  8'hFF, 1'b0, 8'h00, 32'h0},
        '{MODE_CIPHER, 8'h55, 1'b0, 8'h00, 32'h0},
        '{MODE_REWIND, 8'hAA, 1'b1, 8'h00, 32'h0000_0000},
        '{MODE_CLEAR,  8'h00, 1'b0, 8'h00, 32'h0},
        '{MODE_CIPHER, 8'hAA, 1'b0, 8'h00, 32'h0}
    };

    name_keyed_plaintext_feedback_decipher_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    function automatic result_t advance_keystream(input mode_t m, input logic [7:0] b);
        result_t     r;
        logic [7:0]  plain;
        logic [31:0] plain_ext;
        plain = 8'h00;
        case (m)
            MODE_NAME:
            begin
                if (b == SEP_SLASH || b == SEP_BACKSLASH)
                    name_key = '0;
                else
                    name_key = name_key * HASH_MUL + {24'h0, b};
                stream_key = name_key;
            end
            MODE_CIPHER:
            begin
                plain = b ^ stream_key[15:8];
                plain_ext = {{24{plain[7]}}, plain};
                stream_key = stream_key * MUL_STEP + ADD_STEP * plain_ext;
            end
            MODE_REWIND:
                stream_key = name_key;
            default:
                name_key = '0;
        endcase
        r.data_out = plain;
        r.key_value = stream_key;
        return r;
    endfunction

    // Drive one transaction and record its expected result once it is taken.
    task automatic send_byte(input mode_t m, input logic [7:0] b,
                             input logic typed, input result_t typed_exp);
        result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= m;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = advance_keystream(m, b);
        pending_plain.push_back(typed ? typed_exp : predicted);
        items_sent++;
        mode_seen[m]++;
    endtask

    task automatic send_plain(input mode_t m, input logic [7:0] b);
        send_byte(m, b, 1'b0, '0);
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_plain.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_name_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return ($urandom_range(1) != 0) ? SEP_SLASH : SEP_BACKSLASH;
        else if (roll < 20)
            return 8'($urandom_range(255));
        else
            return 8'($urandom_range(8'h7E, 8'h20));
    endfunction

    // Mostly whole files: an optional clear, a name, an optional rewind, a run of cipher bytes; the rest is noise.
    task automatic run_random(input int count);
        int target;
        int len;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(9) < 7)
            begin
                if ($urandom_range(3) == 0)
                    send_plain(MODE_CLEAR, 8'($urandom_range(255)));
                len = $urandom_range(12, 1);
                repeat (len) send_plain(MODE_NAME, pick_name_char());
                if ($urandom_range(1) != 0)
                    send_plain(MODE_REWIND, 8'($urandom_range(255)));
                len = $urandom_range(24, 1);
                repeat (len) send_plain(MODE_CIPHER, 8'($urandom_range(255)));
                if ($urandom_range(4) == 0)
                begin
                    send_plain(MODE_REWIND, 8'($urandom_range(255)));
                    len = $urandom_range(8, 1);
                    repeat (len) send_plain(MODE_CIPHER, 8'($urandom_range(255)));
                end
            end
            else
            begin
                len = $urandom_range(6, 1);
                repeat (len) send_plain(mode_t'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata);
            if (pending_plain.size() == 0)
            begin
                $error("unexpected result transaction: tdata %010h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_plain.pop_front();
                results_checked++;
                if (got.data_out !== want.data_out)
                begin
                    $error("data_out mismatch: expected %02h, got %02h",
                           want.data_out, got.data_out);
                    fail_count++;
                end
                if (got.key_value !== want.key_value)
                begin
                    $error("key_value mismatch: expected %08h, got %08h",
                           want.key_value, got.key_value);
                    fail_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timed out with %0d results outstanding", pending_plain.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        result_t typed_exp;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_exp.data_out = directed_rows[i].exp_plain;
            typed_exp.key_value = directed_rows[i].exp_key;
            send_byte(directed_rows[i].mode, directed_rows[i].byte_val,
                      directed_rows[i].typed, typed_exp);
        end

        run_random(PHASE_ITEMS);
        drain_results();

        src_idle_pct = 54;
        sink_stall_pct = 30;
        run_random(PHASE_ITEMS);

        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: %0d name, %0d cipher, %0d rewind, %0d clear.",
                 items_sent, mode_seen[MODE_NAME], mode_seen[MODE_CIPHER],
                 mode_seen[MODE_REWIND], mode_seen[MODE_CLEAR]);
        $display("Checked %0d results under three source/sink stall mixes.",
                 results_checked);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/nkpfd_pkg.sv
sv/nkpfd_in_reg.sv
sv/nkpfd_keystream.sv
sv/name_keyed_plaintext_feedback_decipher_core.sv
sv/nkpfd_checker.sv
test/testbench.sv
